FILE: rtl/c3lr_pkg.sv
// Package for the 3x3 convolution layer with leaky ReLU.
// Payload structs, command codes, sequencer states and fixed-point constants.
// No dependencies.
`default_nettype none
package c3lr_pkg;

  localparam int MaxInPlanes  = 32;
  localparam int MaxOutPlanes = 32;
  localparam int MaxWidth     = 64;
  localparam int MaxHeight    = 64;
  localparam int KernelTaps   = 9;

  localparam int LeakQ16 = 6554;  // 0.1 in Q0.16

  localparam logic [1:0] CmdWeight  = 2'd0;
  localparam logic [1:0] CmdBias    = 2'd1;
  localparam logic [1:0] CmdSample  = 2'd2;
  localparam logic [1:0] CmdCompute = 2'd3;

  localparam logic [1:0] RegInPlanes  = 2'd0;
  localparam logic [1:0] RegOutPlanes = 2'd1;
  localparam logic [1:0] RegWidth     = 2'd2;
  localparam logic [1:0] RegHeight    = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         out_index;
    logic [4:0]         in_index;
    logic [3:0]         tap;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         plane;
    logic signed [15:0] sample;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BIAS,
    S_BIASW,
    S_RD,
    S_MUL,
    S_ACC,
    S_ACT1,
    S_ACT2,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/conv3x3_layer_leaky_relu_top.sv
// A compute transfer starts the sequencer: per output plane, bias read (S_BIAS, S_BIASW), then
// S_RD, S_MUL, S_ACC per tap on one shared MAC, S_ACT1, S_ACT2 and S_OUT, plus stalls.
// Load commands are written on transfer. Throughput: one item at a time, not ready while busy.
// Reset (rst_ni, async low) clears the sequencer and sets registers to
// in 1, out 1, width 64, height 64. Stores are not cleared.
// Top level: sequencer, stores, shared 16x16 MAC, leaky ReLU output stage.
// Depends on c3lr_pkg.
`default_nettype none
module conv3x3_layer_leaky_relu_top #(
  parameter int MAX_IN_PLANES  = c3lr_pkg::MaxInPlanes,
  parameter int MAX_OUT_PLANES = c3lr_pkg::MaxOutPlanes,
  parameter int MAX_WIDTH      = c3lr_pkg::MaxWidth,
  parameter int MAX_HEIGHT     = c3lr_pkg::MaxHeight
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  c3lr_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output c3lr_pkg::out_item_t  out_item_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [1:0]            cfg_index_i,
  input  wire [6:0]            cfg_data_i
);
  import c3lr_pkg::*;

  localparam int PW  = (MAX_IN_PLANES  > 1) ? $clog2(MAX_IN_PLANES)  : 1;
  localparam int OW  = (MAX_OUT_PLANES > 1) ? $clog2(MAX_OUT_PLANES) : 1;
  localparam int HW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int ICW = $clog2(MAX_IN_PLANES + 1);
  localparam int OCW = $clog2(MAX_OUT_PLANES + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int SDEPTH = MAX_IN_PLANES * MAX_HEIGHT * MAX_WIDTH;
  localparam int WDEPTH = MAX_OUT_PLANES * MAX_IN_PLANES * KernelTaps;
  localparam int SAW = $clog2(SDEPTH);
  localparam int WAW = $clog2(WDEPTH);

  state_e state_q, state_d;

  logic [ICW-1:0] in_used_q;
  logic [OCW-1:0] out_used_q;
  logic [WCW-1:0] width_q;
  logic [HCW-1:0] height_q;

  logic [5:0]     row_q, col_q;
  logic [OW-1:0]  o_q;
  logic [PW-1:0]  p_q;
  logic [1:0]     kr_q, kc_q;

  logic signed [15:0] sample_mem [SDEPTH];
  logic signed [15:0] weight_mem [WDEPTH];
  logic signed [15:0] bias_mem   [MAX_OUT_PLANES];
  logic signed [15:0] s_rd_q, w_rd_q, b_rd_q;
  logic signed [31:0] prod_q;
  logic signed [39:0] acc_q;
  logic signed [53:0] neg_q;

  logic      in_xfer, out_xfer, last_plane, last_in, busy_out;
  out_item_t out_q;
  logic      out_valid_q;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign last_plane = (OCW'(o_q) + OCW'(1)) == out_used_q;
  assign last_in    = (ICW'(p_q) + ICW'(1)) == in_used_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // configuration, clamped to 1..MAX
  function automatic int clamp_reg(input logic [6:0] v, input int hi);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > hi) r = hi;
    return r;
  endfunction

  // plane counts use only the low six bits of the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_used_q  <= ICW'(1);
      out_used_q <= OCW'(1);
      width_q    <= WCW'(clamp_reg(7'd64, MAX_WIDTH));
      height_q   <= HCW'(clamp_reg(7'd64, MAX_HEIGHT));
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegInPlanes:
          in_used_q  <= ICW'(clamp_reg({1'b0, cfg_data_i[5:0]}, MAX_IN_PLANES));
        RegOutPlanes:
          out_used_q <= OCW'(clamp_reg({1'b0, cfg_data_i[5:0]}, MAX_OUT_PLANES));
        RegWidth:     width_q    <= WCW'(clamp_reg(cfg_data_i, MAX_WIDTH));
        RegHeight:    height_q   <= HCW'(clamp_reg(cfg_data_i, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // neighbor coordinates, clamped to the image
  logic signed [11:0] rr, cc;
  logic [HW-1:0] r_sel;
  logic [CW-1:0] c_sel;
  always_comb begin
    rr = $signed(12'(row_q) + 12'(kr_q) - 12'd1);
    cc = $signed(12'(col_q) + 12'(kc_q) - 12'd1);
    if (rr < 0) r_sel = '0;
    else if (rr >= $signed(12'(height_q))) r_sel = HW'(height_q - HCW'(1));
    else r_sel = HW'(rr);
    if (cc < 0) c_sel = '0;
    else if (cc >= $signed(12'(width_q))) c_sel = CW'(width_q - WCW'(1));
    else c_sel = CW'(cc);
  end

  logic [SAW-1:0] s_raddr, s_waddr;
  logic [WAW-1:0] w_raddr, w_waddr;
  logic s_we, w_we, b_we;
  always_comb begin
    s_raddr = SAW'((int'(p_q) * MAX_HEIGHT + int'(r_sel)) * MAX_WIDTH + int'(c_sel));
    w_raddr = WAW'((int'(o_q) * MAX_IN_PLANES + int'(p_q)) * KernelTaps
                   + int'(kr_q) * 3 + int'(kc_q));
    s_waddr = SAW'((int'(in_item_i.in_index) * MAX_HEIGHT + int'(in_item_i.row))
                   * MAX_WIDTH + int'(in_item_i.col));
    w_waddr = WAW'((int'(in_item_i.out_index) * MAX_IN_PLANES + int'(in_item_i.in_index))
                   * KernelTaps + int'(in_item_i.tap));
    w_we = in_xfer && in_item_i.cmd == CmdWeight && int'(in_item_i.tap) < KernelTaps
           && int'(in_item_i.out_index) < MAX_OUT_PLANES
           && int'(in_item_i.in_index) < MAX_IN_PLANES;
    b_we = in_xfer && in_item_i.cmd == CmdBias
           && int'(in_item_i.out_index) < MAX_OUT_PLANES;
    s_we = in_xfer && in_item_i.cmd == CmdSample
           && int'(in_item_i.in_index) < MAX_IN_PLANES
           && int'(in_item_i.row) < MAX_HEIGHT && int'(in_item_i.col) < MAX_WIDTH;
  end

  always_ff @(posedge clk_i) begin
    if (s_we) sample_mem[s_waddr] <= in_item_i.value;
    s_rd_q <= sample_mem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) weight_mem[w_waddr] <= in_item_i.value;
    w_rd_q <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bias_mem[OW'(in_item_i.out_index)] <= in_item_i.value;
    b_rd_q <= bias_mem[o_q];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer && in_item_i.cmd == CmdCompute) state_d = S_BIAS;
      S_BIAS:  state_d = S_BIASW;
      S_BIASW: state_d = S_RD;
      S_RD:    state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = (kr_q == 2'd2 && kc_q == 2'd2 && last_in) ? S_ACT1 : S_RD;
      S_ACT1:  state_d = S_ACT2;
      S_ACT2:  state_d = S_OUT;
      S_OUT:   if (out_xfer) state_d = last_plane ? S_IDLE : S_BIAS;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = state_q != S_IDLE;
    busy_out   = state_q == S_OUT;
  end

  // activation: rounding, leak and saturation
  logic signed [53:0] y;
  logic signed [15:0] y_sat;
  always_comb begin
    if (acc_q[39]) y = (neg_q + (54'sd1 <<< 29)) >>> 30;
    else           y = (54'(acc_q) + 54'sd8192) >>> 14;
    if (y > 54'sd32767)       y_sat = 16'sh7fff;
    else if (y < -54'sd32768) y_sat = -16'sh8000;
    else                      y_sat = 16'(y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      o_q         <= '0;
      p_q         <= '0;
      kr_q        <= '0;
      kc_q        <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          o_q <= '0;
          if (in_xfer) begin
            row_q <= in_item_i.row;
            col_q <= in_item_i.col;
          end
        end
        S_BIASW: begin
          acc_q <= {{10{b_rd_q[15]}}, b_rd_q, 14'b0};
          p_q   <= '0;
          kr_q  <= '0;
          kc_q  <= '0;
        end
        S_MUL: prod_q <= s_rd_q * w_rd_q;
        S_ACC: begin
          acc_q <= acc_q + 40'(prod_q);
          if (kc_q != 2'd2) kc_q <= kc_q + 2'd1;
          else begin
            kc_q <= '0;
            if (kr_q != 2'd2) kr_q <= kr_q + 2'd1;
            else begin
              kr_q <= '0;
              if (!last_in) p_q <= p_q + PW'(1);
            end
          end
        end
        S_ACT1: neg_q <= 54'(acc_q) * 54'(LeakQ16);
        S_ACT2: begin
          out_q.plane  <= 5'(o_q);
          out_q.sample <= y_sat;
          out_q.last   <= last_plane;
          out_valid_q  <= 1'b1;
        end
        S_OUT: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (!last_plane) o_q <= o_q + OW'(1);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_out)
    else $error("result shown outside output state");
  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_item_i.cmd == CmdCompute) |=> state_q == S_BIAS)
    else $error("compute transfer did not start sequencer");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_item_o.last) |=> (state_q == S_IDLE && !out_valid_o))
    else $error("last result did not return to idle");
`endif

endmodule
`default_nettype wire
